FILE: src/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg
// shared types, constants and the per-mode compression parameters of the
// coefficient compress packer
// ----------------------------------------------------------------------------
package ccp_pkg;

   localparam int COEFFS_PER_POLY = 256;
   localparam int IDX_W           = $clog2(COEFFS_PER_POLY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COEFFS_PER_POLY - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int COEFF_W = 14;
   localparam int MODE_W  = 2;

   localparam logic [MODE_W-1:0] MODE_Q3329_L4 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_Q3329_L5 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_Q7681_L4 = 2'd2;

   typedef struct packed {
      logic [12:0] q;
      logic        l5;
      logic [11:0] bias;
      logic [16:0] mult;
   } param_type;

   // one compressed value on its way from the front to the packer
   typedef struct packed {
      logic       l5;
      logic [4:0] value;
   } qentry_type;

   function automatic param_type mode_params(input logic [MODE_W-1:0] mode);
      param_type p;
      unique case (mode)
         MODE_Q3329_L5: begin
            p.q = 13'd3329; p.l5 = 1'b1; p.bias = 12'd1664; p.mult = 17'd40318;
         end
         MODE_Q7681_L4: begin
            p.q = 13'd7681; p.l5 = 1'b0; p.bias = 12'd3840; p.mult = 17'd34948;
         end
         default: begin
            p.q = 13'd3329; p.l5 = 1'b0; p.bias = 12'd1665; p.mult = 17'd80635;
         end
      endcase
      return p;
   endfunction

endpackage

FILE: src/ccp_front.sv
// ----------------------------------------------------------------------------
// ccp_front
// two-stage front: modulus fix-up and pre-scale, then the constant multiply
// and extraction of the compressed value
// ----------------------------------------------------------------------------
module ccp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ccp_pkg::MODE_W-1:0]    mode,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ccp_pkg::COEFF_W-1:0] req_coefficient,
   output logic                          push,
   output ccp_pkg::qentry_type           push_entry,
   input  logic                          q_ready
);
   import ccp_pkg::*;

   param_type   par;
   logic [31:0] c_ext;
   logic [31:0] u;
   logic [31:0] a;
   logic [31:0] prod;
   logic        req_transfer;
   logic        s1_move;
   logic        s2_free;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_a_ff;
   logic [16:0] s1_mult_ff;
   logic        s1_l5_ff;
   logic        s2_valid_ff, s2_valid_in;
   qentry_type  s2_entry_ff, s2_entry_in;

   always_comb begin
      par   = mode_params(mode);
      c_ext = {{(32-COEFF_W){req_coefficient[COEFF_W-1]}}, req_coefficient};
      u     = req_coefficient[COEFF_W-1] ? c_ext + {19'b0, par.q} : c_ext;
      a     = (par.l5 ? {u[26:0], 5'b0} : {u[27:0], 4'b0}) + {20'b0, par.bias};
   end

   assign s2_free      = !s2_valid_ff || q_ready;
   assign s1_move      = s1_valid_ff && s2_free;
   assign req_ready    = !s1_valid_ff || s2_free;
   assign req_transfer = req_valid && req_ready;
   assign s1_valid_in  = (s1_valid_ff && !s2_free) || req_transfer;
   assign s2_valid_in  = (s2_valid_ff && !q_ready) || s1_move;

   always_comb begin
      prod              = s1_a_ff * {15'b0, s1_mult_ff};
      s2_entry_in.l5    = s1_l5_ff;
      s2_entry_in.value = s1_l5_ff ? prod[31:27] : {1'b0, prod[31:28]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_a_ff    <= a;
         s1_mult_ff <= par.mult;
         s1_l5_ff   <= par.l5;
      end
      if (s1_move) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

   assign push       = s2_valid_ff && q_ready;
   assign push_entry = s2_entry_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && !q_ready) |-> !req_ready)
      else $error("front accepted a transfer with both stages blocked");
   a_stage2_kept: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !q_ready) |=> (s2_valid_ff && $stable(s2_entry_ff)))
      else $error("stalled multiply result lost");
   a_stage1_flows: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> s2_valid_ff)
      else $error("stage one moved but stage two empty");
`endif

endmodule

FILE: src/ccp_queue.sv
// ----------------------------------------------------------------------------
// ccp_queue
// short queue of compressed values between the front and the packer
// ----------------------------------------------------------------------------
module ccp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ccp_pkg::qentry_type push_entry,
   output logic                q_ready,
   output logic                q_valid,
   output ccp_pkg::qentry_type q_entry,
   input  logic                pop
);
   import ccp_pkg::*;

   qentry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

FILE: src/ccp_back.sv
// ----------------------------------------------------------------------------
// ccp_back
// bit packer: gathers compressed values into bytes, tracks the position in
// the polynomial and holds the outgoing byte in an output register
// ----------------------------------------------------------------------------
module ccp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  ccp_pkg::qentry_type q_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_byte
);
   import ccp_pkg::*;

   logic [11:0]      buf_ff, buf_in;
   logic [3:0]       held_ff, held_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff;
   logic             last_ff;

   logic [11:0] merged;
   logic [3:0]  sum;
   logic        at_last;
   logic        emit;

   assign pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign at_last = idx_ff == LAST_IDX;

   always_comb begin
      merged  = buf_ff | ({7'b0, q_entry.value} << held_ff);
      sum     = held_ff + (q_entry.l5 ? 4'd5 : 4'd4);
      buf_in  = buf_ff;
      held_in = held_ff;
      idx_in  = idx_ff;
      emit    = 1'b0;
      if (pop) begin
         if (at_last) begin
            emit    = 1'b1;
            buf_in  = '0;
            held_in = '0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
            if (sum >= 4'd8) begin
               emit    = 1'b1;
               buf_in  = {8'b0, merged[11:8]};
               held_in = sum - 4'd8;
            end else begin
               buf_in  = merged;
               held_in = sum;
            end
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         held_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= merged[7:0];
         last_ff <= at_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

`ifndef NO_ASSERTIONS
   a_held_below_byte: assert property (@(posedge clock) disable iff (reset)
      held_ff < 4'd8)
      else $error("packer holds a full byte");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && at_last) |=> (idx_ff == '0 && held_ff == '0 && buf_ff == '0
                             && rsp_valid_ff && rsp_last_byte))
      else $error("end of polynomial not handled");
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (pop && !at_last) |=> idx_ff == $past(idx_ff) + 1'b1)
      else $error("coefficient index did not advance");
   a_buf_fits: assert property (@(posedge clock) disable iff (reset)
      (held_ff <= 4'd4) |-> (buf_ff[11:8] == 4'b0))
      else $error("stale bits above the held count");
`endif

endmodule

FILE: src/coefficient_compress_packer.sv
// ----------------------------------------------------------------------------
// coefficient_compress_packer
// compresses signed polynomial coefficients to 4 or 5 bits and packs them
// LSB-first into bytes, flagging the last byte of each polynomial
// ----------------------------------------------------------------------------
// One coefficient is taken per clock cycle, sustained, while rsp_ready
// stays high. A coefficient passes a pre-scale stage and a constant-multiply
// stage, waits in a four-entry queue and is packed by a bit buffer update
// into the byte output register; the first byte it completes goes through
// the stage-one, stage-two, queue and output registers. Throughput is set
// by the packer, which takes one value per cycle while the output register
// is free or being emptied. The mode register selects the modulus and width
// (0: 3329 with 4 bits, 1: 3329 with 5 bits, 2: 7681 with 4 bits, 3 as 0);
// the user must write it only while no transfer is in flight, and the block does not enforce this.
module coefficient_compress_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ccp_pkg::MODE_W-1:0]          csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ccp_pkg::COEFF_W-1:0]  req_coefficient,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last_byte
);
   import ccp_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic              push;
   qentry_type        push_entry;
   logic              q_ready;
   logic              q_valid;
   qentry_type        q_entry;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_Q3329_L4;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   ccp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .mode            (mode_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coefficient (req_coefficient),
      .push            (push),
      .push_entry      (push_entry),
      .q_ready         (q_ready)
   );

   ccp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_ready    (q_ready),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop)
   );

   ccp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the coefficient compress packer: a directed table of
// corner coefficients and mode writes, then random phases under bursty
// sender traffic and receiver stalls, every byte checked against an in-bench
// packing predictor
// ----------------------------------------------------------------------------
module tb_top;
   import ccp_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int DIRECTED_ROWS  = 28;

   localparam logic [MODE_W-1:0] MODE_ALIAS_Q3329_L4 = 2'd3;
   localparam int unsigned MASK_L5 = 32'h1f;
   localparam int unsigned MASK_L4 = 32'hf;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } packed_byte_type;

   typedef enum logic {ROW_SEND, ROW_MODE} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      int                coeff;
      logic [MODE_W-1:0] mode;
      bit                typed;
      logic [7:0]        typed_byte;
   } stimulus_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [MODE_W-1:0]         csr_write_data = MODE_Q3329_L4;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COEFF_W-1:0] req_coefficient = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_out_byte;
   logic                      rsp_last_byte;

   // predictor state
   logic [MODE_W-1:0] active_mode = MODE_Q3329_L4;
   int unsigned       pack_bits = 0;
   int unsigned       pack_count = 0;
   int unsigned       coeff_position = 0;
   packed_byte_type   expected_bytes[$];

   int fault_count = 0;
   int burst_left = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int pattern_left = 0;
   int ready_style = 0;

   const logic [MODE_W-1:0] mode_sweep [4] =
      '{MODE_Q3329_L4, MODE_Q3329_L5, MODE_Q7681_L4, MODE_ALIAS_Q3329_L4};

   // at reset the buffer is empty and mode is 0: two zeros make 0x00,
   // two midpoints (compress to 8) make 0x88
   const stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SEND,     0, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND,     0, MODE_Q3329_L4,       1'b1, 8'h00},
      '{ROW_SEND,  1665, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND,  1665, MODE_Q3329_L4,       1'b1, 8'h88},
      '{ROW_SEND,  3328, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND, -3328, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND,  8191, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND, -8192, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND,  7680, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND, -7680, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND,     1, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_SEND,    -1, MODE_Q3329_L4,       1'b0, 8'h00},
      '{ROW_MODE,     0, MODE_Q3329_L5,       1'b0, 8'h00},
      '{ROW_SEND, -3328, MODE_Q3329_L5,       1'b0, 8'h00},
      '{ROW_SEND,  3328, MODE_Q3329_L5,       1'b0, 8'h00},
      '{ROW_SEND,  8191, MODE_Q3329_L5,       1'b0, 8'h00},
      '{ROW_SEND, -8192, MODE_Q3329_L5,       1'b0, 8'h00},
      '{ROW_MODE,     0, MODE_Q7681_L4,       1'b0, 8'h00},
      '{ROW_SEND,  7680, MODE_Q7681_L4,       1'b0, 8'h00},
      '{ROW_SEND, -7680, MODE_Q7681_L4,       1'b0, 8'h00},
      '{ROW_SEND,     0, MODE_Q7681_L4,       1'b0, 8'h00},
      '{ROW_SEND, -8192, MODE_Q7681_L4,       1'b0, 8'h00},
      '{ROW_SEND,  8191, MODE_Q7681_L4,       1'b0, 8'h00},
      '{ROW_MODE,     0, MODE_ALIAS_Q3329_L4, 1'b0, 8'h00},
      '{ROW_SEND,  1665, MODE_ALIAS_Q3329_L4, 1'b0, 8'h00},
      '{ROW_SEND, -1665, MODE_ALIAS_Q3329_L4, 1'b0, 8'h00},
      '{ROW_SEND,   100, MODE_ALIAS_Q3329_L4, 1'b0, 8'h00},
      '{ROW_MODE,     0, MODE_Q3329_L4,       1'b0, 8'h00}
   };

   coefficient_compress_packer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coefficient  (req_coefficient),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_byte    (rsp_last_byte)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [4:0] compress_coefficient(logic signed [COEFF_W-1:0] c,
                                                      logic [MODE_W-1:0] m);
      int unsigned q, lbits, bias, mult, shift;
      int          s;
      logic [31:0] d;
      case (m)
         MODE_Q3329_L5: begin
            q = 3329; lbits = 5; bias = 1664; mult = 40318; shift = 27;
         end
         MODE_Q7681_L4: begin
            q = 7681; lbits = 4; bias = 3840; mult = 34948; shift = 28;
         end
         default: begin
            q = 3329; lbits = 4; bias = 1665; mult = 80635; shift = 28;
         end
      endcase
      s = c;
      if (s < 0) s = s + int'(q);
      // 32-bit wraparound throughout
      d = 32'(s);
      d = d << lbits;
      d = d + bias;
      d = d * mult;
      d = d >> shift;
      d = d & ((lbits == 5) ? MASK_L5 : MASK_L4);
      return d[4:0];
   endfunction

   task automatic pack_coefficient(input logic signed [COEFF_W-1:0] c,
                                   output bit emitted, output packed_byte_type r);
      int unsigned lbits;
      int unsigned v;
      lbits = (active_mode == MODE_Q3329_L5) ? 5 : 4;
      v = compress_coefficient(c, active_mode);
      pack_bits = pack_bits | (v << pack_count);
      pack_count = pack_count + lbits;
      emitted = 1'b0;
      r = '0;
      if (coeff_position >= COEFFS_PER_POLY - 1) begin
         // last byte of the polynomial: low 8 bits, the rest dropped
         emitted = 1'b1;
         r.out_byte = pack_bits[7:0];
         r.last_byte = 1'b1;
         pack_bits = 0;
         pack_count = 0;
         coeff_position = 0;
      end else begin
         coeff_position++;
         if (pack_count >= 8) begin
            emitted = 1'b1;
            r.out_byte = pack_bits[7:0];
            pack_bits = (pack_bits >> 8) & 32'hfff;
            pack_count = pack_count - 8;
         end else begin
            pack_bits = pack_bits & 32'hfff;
         end
      end
   endtask

   function automatic int random_coefficient();
      int q;
      int pick;
      q = (active_mode == MODE_Q7681_L4) ? 7681 : 3329;
      pick = $urandom_range(0, 99);
      if (pick < 70) return int'($urandom_range(0, 2 * q - 2)) - (q - 1);
      if (pick < 82) begin
         case ($urandom_range(0, 7))
            0: return q - 1;
            1: return -(q - 1);
            2: return 0;
            3: return -1;
            4: return q;
            5: return -q;
            6: return 8191;
            default: return -8192;
         endcase
      end
      return int'($urandom_range(0, 16383)) - 8192;
   endfunction

   task automatic offer_coefficient(input int coeff, input bit typed, input logic [7:0] typed_byte);
      bit              emitted;
      packed_byte_type r;
      if (!steady && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (!steady) burst_left--;
      req_valid <= 1'b1;
      req_coefficient <= COEFF_W'(coeff);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pack_coefficient(COEFF_W'(coeff), emitted, r);
      if (emitted) begin
         if (typed) r.out_byte = typed_byte;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_mode = m;
   endtask

   // result side: check each transfer, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected byte transfer: out_byte %0h last_byte %0b",
                   rsp_out_byte, rsp_last_byte);
            fault_count++;
         end else begin
            if (rsp_out_byte !== expected_bytes[0].out_byte) begin
               $error("out_byte: expected %0h, actual %0h",
                      expected_bytes[0].out_byte, rsp_out_byte);
               fault_count++;
            end
            if (rsp_last_byte !== expected_bytes[0].last_byte) begin
               $error("last_byte: expected %0b, actual %0b",
                      expected_bytes[0].last_byte, rsp_last_byte);
               fault_count++;
            end
            void'(expected_bytes.pop_front());
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
         ready_style = $urandom_range(0, 3);
         pattern_left = $urandom_range(16, 128);
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin
      int  phase;
      int  random_sent;
      int  count;
      bit  pressure;
      phase = 0;
      random_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_MODE) begin
            write_mode(directed_rows[i].mode);
         end else begin
            offer_coefficient(directed_rows[i].coeff, directed_rows[i].typed,
                              directed_rows[i].typed_byte);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         if (phase < 4) write_mode(mode_sweep[phase]);
         else write_mode(mode_sweep[$urandom_range(0, 3)]);
         pressure = (phase == 5) || ($urandom_range(0, 9) == 0);
         steady = pressure || ($urandom_range(0, 4) == 0);
         count = pressure ? 80 : $urandom_range(1, 300);
         // receiver goes quiet while the sender keeps pushing
         if (pressure) hold_request = 1'b1;
         repeat (count) offer_coefficient(random_coefficient(), 1'b0, 8'h00);
         steady = 1'b0;
         random_sent += count;
         phase++;
      end

      settle_block();
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
